// File: rtl/core/cba_pkg.sv
// Shared types and codes for the compacting block allocator.
// Depends on nothing; cba_cell and the allocator top import it.
`default_nettype none
package cba_pkg;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP  = 2'd2;
  localparam logic [1:0] ACT_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_NOSPACE  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [15:0] BLOCK_SIZE_RESET  = 16'd512;
  localparam logic [10:0] BLOCK_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  owner_tag;
    logic [31:0] byte_size;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  first_block;
    logic [10:0] block_span;
    logic [31:0] file_bytes;
    logic [10:0] free_blocks;
    logic [10:0] used_blocks;
  } out_word_t;

  typedef struct packed {
    logic rotate;
    logic compact;
  } cba_mode_t;

endpackage
`default_nettype wire

// File: rtl/core/cba_div.sv
// Restoring divider, one quotient bit per cycle, for the block count.
// Depends on nothing outside this file.
`default_nettype none
module cba_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] num,
  input  logic [15:0]  den,
  output logic         done,
  output logic [W-1:0] quot,
  output logic         rem_nz
);
  localparam int NW = $clog2(W + 1);

  logic [W-1:0]  q;
  logic [16:0]   r;
  logic [15:0]   den_r;
  logic [NW-1:0] cnt;
  logic          running;
  logic [16:0]   r_sh;

  assign r_sh   = {r[15:0], q[W-1]};
  assign quot   = q;
  assign rem_nz = (r != 17'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= !go && running && (cnt == NW'(1));
      if (go) begin
        running <= 1'b1;
        cnt     <= NW'(W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q     <= num;
      r     <= '0;
      den_r <= den;
    end else if (running) begin
      if (r_sh >= {1'b0, den_r}) begin
        r <= r_sh - {1'b0, den_r};
        q <= {q[W-2:0], 1'b1};
      end else begin
        r <= r_sh;
        q <= {q[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/cba_cell.sv
// One table entry of the allocator chain: used mark, owner tag, byte size.
// Depends on cba_pkg for the mode struct.
`default_nettype none
module cba_cell #(
  parameter int TAG_BITS  = 8,
  parameter int SIZE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cba_pkg::cba_mode_t    mode,
  input  logic                  own_act,
  input  logic                  nxt_act,
  input  logic                  prv_used,
  input  logic                  nxt_used,
  input  logic [TAG_BITS-1:0]   nxt_owner,
  input  logic [SIZE_BITS-1:0]  nxt_bytes,
  output logic                  used,
  output logic [TAG_BITS-1:0]   owner,
  output logic [SIZE_BITS-1:0]  bytes
);
  import cba_pkg::*;

  logic mv_in;
  logic mv_out;

  // An entry moves down one place when the place below is empty.
  assign mv_in  = mode.compact && nxt_act && !used && nxt_used;
  assign mv_out = mode.compact && own_act && !prv_used && used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (mode.rotate) begin
      used <= nxt_used;
    end else if (mv_in) begin
      used <= 1'b1;
    end else if (mv_out) begin
      used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mode.rotate || mv_in) begin
      owner <= nxt_owner;
      bytes <= nxt_bytes;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/compacting_block_allocator.sv
// Compacting first-fit block allocator: a ring of entry cells and its control.
// Depends on cba_pkg, cba_div and cba_cell.
// From start to done, query and lookup take one ring rotation; allocate first runs
// the divider and, when placed, adds a second rotation to fill; a release that
// hits adds the compaction sweep after its rotation. One command at a time; the
// receiver cannot stall.
// Reset frees every block at once and restores block size 512 and count 1024.
`default_nettype none
module compacting_block_allocator #(
  parameter int NUM_BLOCKS = 1024,
  parameter int TAG_BITS   = 8,
  parameter int SIZE_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cba_pkg::in_word_t  cmd,
  output logic               done,
  output cba_pkg::out_word_t result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import cba_pkg::*;

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int MW = (SIZE_BITS > CW) ? SIZE_BITS : CW;
  localparam int PW = $clog2(2 * NUM_BLOCKS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_EVAL = 7'b0001000,
    S_FILL = 7'b0010000,
    S_PACK = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;

  logic [15:0]          block_size;
  logic [10:0]          block_count;
  logic [CW-1:0]        cnt;

  logic [1:0]           act_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic [SIZE_BITS-1:0] size_r;
  logic [IW-1:0]        pos;
  logic [PW-1:0]        cyc;
  logic                 hit;
  logic [IW-1:0]        first;
  logic [CW-1:0]        span;
  logic [SIZE_BITS-1:0] fbytes;
  logic [CW-1:0]        used_cnt;
  logic [CW-1:0]        run;
  logic                 found;
  logic [IW-1:0]        start_ix;
  logic [CW-1:0]        need_n;
  logic                 need_ok;
  logic                 need_zero;
  out_word_t            res;
  out_word_t            res_next;

  logic                 div_go;
  logic                 div_done;
  logic [SIZE_BITS-1:0] div_q;
  logic                 div_rnz;
  logic [MW-1:0]        need_full;

  cba_mode_t            mode;
  logic [NUM_BLOCKS-1:0] used_v;
  logic [NUM_BLOCKS-1:0] prv_v;
  logic [NUM_BLOCKS:0]   act_v;
  logic [TAG_BITS-1:0]   owner_a [NUM_BLOCKS];
  logic [SIZE_BITS-1:0]  bytes_a [NUM_BLOCKS];
  logic                  tail_used;
  logic [TAG_BITS-1:0]   tail_owner;
  logic [SIZE_BITS-1:0]  tail_bytes;

  logic                 accept;
  logic                 last;
  logic                 act_h;
  logic                 match;
  logic                 in_range;
  logic [CW-1:0]        run_inc;

  assign cnt = (32'(block_count) > 32'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(block_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size  <= BLOCK_SIZE_RESET;
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE:  block_size  <= cfg_data;
        REG_BLOCK_COUNT: block_count <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign result = res;
  assign accept = start && !busy;
  assign div_go = accept && (cmd.action == ACT_ALLOC);

  cba_div #(.W(SIZE_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .go     (div_go),
    .num    (SIZE_BITS'(cmd.byte_size)),
    .den    ((block_size == 16'd0) ? 16'd1 : block_size),
    .done   (div_done),
    .quot   (div_q),
    .rem_nz (div_rnz)
  );

  assign need_full = MW'(div_q) + MW'(div_rnz);

  assign mode.rotate  = (state == S_SCAN) || (state == S_FILL);
  assign mode.compact = (state == S_PACK);

  assign last     = (pos == IW'(NUM_BLOCKS - 1));
  assign act_h    = (CW'(pos) < cnt);
  assign match    = act_h && used_v[0] && (owner_a[0] == tag_r);
  assign run_inc  = run + 1'b1;
  assign in_range = (CW'(pos) >= CW'(start_ix)) && (CW'(pos) < CW'(start_ix) + need_n);

  always_comb begin
    tail_used  = used_v[0];
    tail_owner = owner_a[0];
    tail_bytes = bytes_a[0];
    if (state == S_FILL && in_range) begin
      tail_used  = 1'b1;
      tail_owner = tag_r;
      tail_bytes = size_r;
    end else if (state == S_SCAN && act_r == ACT_RELEASE && match) begin
      tail_used = 1'b0;
    end
  end

  assign prv_v = {used_v[NUM_BLOCKS-2:0], 1'b1};
  assign act_v[NUM_BLOCKS] = 1'b0;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    logic                 n_used;
    logic [TAG_BITS-1:0]  n_owner;
    logic [SIZE_BITS-1:0] n_bytes;

    assign act_v[g] = (CW'(g) < cnt);

    if (g == NUM_BLOCKS - 1) begin : g_tail
      assign n_used  = tail_used;
      assign n_owner = tail_owner;
      assign n_bytes = tail_bytes;
    end else begin : g_next
      assign n_used  = used_v[g+1];
      assign n_owner = owner_a[g+1];
      assign n_bytes = bytes_a[g+1];
    end

    cba_cell #(.TAG_BITS(TAG_BITS), .SIZE_BITS(SIZE_BITS)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .mode      (mode),
      .own_act   (act_v[g]),
      .nxt_act   (act_v[g+1]),
      .prv_used  (prv_v[g]),
      .nxt_used  (n_used),
      .nxt_owner (n_owner),
      .nxt_bytes (n_bytes),
      .used      (used_v[g]),
      .owner     (owner_a[g]),
      .bytes     (bytes_a[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (cmd.action == ACT_ALLOC) ? S_DIV : S_SCAN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (act_r == ACT_ALLOC && !hit && !need_zero && found) begin
            state <= S_FILL;
          end else if (act_r == ACT_RELEASE && hit) begin
            state <= S_PACK;
          end else begin
            state <= S_DONE;
          end
        end
        S_FILL: begin
          if (last) begin
            state <= S_DONE;
          end
        end
        S_PACK: begin
          if (cyc == PW'(2 * NUM_BLOCKS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res_next = '0;
    res_next.free_blocks = 11'(cnt - used_cnt);
    res_next.used_blocks = 11'(used_cnt);
    case (act_r)
      ACT_ALLOC: begin
        if (hit) begin
          res_next.status = ST_DUP;
        end else if (need_zero) begin
          res_next.status = ST_OK;
        end else if (found) begin
          res_next.status      = ST_OK;
          res_next.first_block = 10'(start_ix);
          res_next.block_span  = 11'(need_n);
          res_next.free_blocks = 11'(cnt - used_cnt - need_n);
          res_next.used_blocks = 11'(used_cnt + need_n);
        end else begin
          res_next.status = ST_NOSPACE;
        end
      end
      ACT_RELEASE: begin
        if (hit) begin
          res_next.first_block = 10'(first);
          res_next.block_span  = 11'(span);
          res_next.free_blocks = 11'(cnt - used_cnt + span);
          res_next.used_blocks = 11'(used_cnt - span);
        end else begin
          res_next.status = ST_NOTFOUND;
        end
      end
      ACT_LOOKUP: begin
        if (hit) begin
          res_next.first_block = 10'(first);
          res_next.block_span  = 11'(span);
          res_next.file_bytes  = 32'(fbytes);
        end else begin
          res_next.status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        act_r    <= cmd.action;
        tag_r    <= TAG_BITS'(cmd.owner_tag);
        size_r   <= SIZE_BITS'(cmd.byte_size);
        pos      <= '0;
        cyc      <= '0;
        hit      <= 1'b0;
        first    <= '0;
        span     <= '0;
        fbytes   <= '0;
        used_cnt <= '0;
        run      <= '0;
        found    <= 1'b0;
        start_ix <= '0;
        need_n   <= '0;
        need_ok  <= 1'b0;
        need_zero <= 1'b1;
      end
      S_DIV: begin
        need_n    <= CW'(need_full);
        need_zero <= (need_full == '0);
        need_ok   <= (need_full != '0) && (need_full <= MW'(cnt));
      end
      S_SCAN: begin
        pos <= pos + 1'b1;
        if (match) begin
          if (!hit) begin
            hit    <= 1'b1;
            first  <= pos;
            fbytes <= bytes_a[0];
          end
          span <= span + 1'b1;
        end
        if (act_h && used_v[0]) begin
          used_cnt <= used_cnt + 1'b1;
        end
        if (act_h) begin
          run <= used_v[0] ? '0 : run_inc;
          if (!found && need_ok && !used_v[0] && run_inc == need_n) begin
            found    <= 1'b1;
            start_ix <= IW'(CW'(pos) + 1'b1 - need_n);
          end
        end
      end
      S_EVAL: begin
        pos <= '0;
        res <= res_next;
      end
      S_FILL: pos <= pos + 1'b1;
      S_PACK: cyc <= cyc + 1'b1;
      default: ;
    endcase
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("Result word strobed while idle.");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("Accepted command did not raise busy.");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("Controller state is not one-hot.");
  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.free_blocks + result.used_blocks == 11'(cnt)))
    else $error("Free and used counts do not add up to the active count.");
  a_fill_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (found && !hit && act_r == ACT_ALLOC))
    else $error("Placement pass without a free run.");
endmodule
`default_nettype wire
